@@ rtl/chs_pkg.sv @@
// Shared types and constants for the chained hash pointer set.
package chs_pkg;

  localparam int KEY_W    = 64;
  localparam int CFG_W    = 9;
  localparam int COUNT_W  = 11;

  // djb2 hash
  localparam logic [KEY_W-1:0] DJB_SEED = 64'd5381;
  localparam int DJB_SHIFT  = 5;
  localparam int HASH_STEPS = 8;

  // remainder unit: bits of the hash retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

@@ rtl/chained_hash_pointer_set.sv @@
// Top level: chained hash set of 64-bit keys with bucket heads and entry pool.
//
//  channel   handshake            payload             direction
//  command   start / busy         cmd (cmd_t)         in
//  result    done (strobe)        result (result_t)   out
//  config    cfg_valid/cfg_ready  cfg_data[8:0]       in
//
// After reset the head table is swept clear, one bucket a cycle, with busy high;
// config writes are taken throughout. An item runs the hash over the key bytes,
// then the remainder (4 bits a cycle), the head read, a read and check per chain
// entry visited, and a finish step.
// busy stays high for the whole item; the result strobe lasts one cycle and
// cannot be held off.
module chained_hash_pointer_set #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  chs_pkg::cmd_t             cmd,
  output logic                      done,
  output chs_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [chs_pkg::CFG_W-1:0] cfg_data
);
  import chs_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_HASH     = 3'd2;
  localparam logic [2:0] ST_HEAD_RD  = 3'd3;
  localparam logic [2:0] ST_HEAD_CHK = 3'd4;
  localparam logic [2:0] ST_ENT_RD   = 3'd5;
  localparam logic [2:0] ST_ENT_CHK  = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] idx;
  } ptr_t;

  logic [2:0]       state;
  logic [BW-1:0]    clr_idx;
  logic [CFG_W-1:0] bucket_count;
  logic [CFG_W-1:0] divisor;
  logic             op;
  logic [KEY_W-1:0] key;
  logic             found;
  logic [CW-1:0]    count;
  logic [BW-1:0]    bucket;
  logic [BW-1:0]    bucket_q;
  logic             unit_start;
  logic             unit_done;
  logic [EW-1:0]    slot;
  ptr_t             head_q;

  // memories
  ptr_t             heads [BUCKETS];
  logic [KEY_W-1:0] keys  [ENTRIES];
  ptr_t             links [ENTRIES];
  ptr_t             head_rdata;
  logic [KEY_W-1:0] key_rdata;
  ptr_t             link_rdata;

  logic             head_we;
  logic [BW-1:0]    head_waddr;
  ptr_t             head_wdata;
  logic             ent_we;
  logic             pool_full;
  logic             do_insert;
  logic [31:0]      count_ext;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (bucket_count == '0) begin
      divisor = CFG_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      divisor = CFG_W'(BUCKETS);
    end else begin
      divisor = bucket_count;
    end
  end

  assign unit_start = (state == ST_IDLE) && start;

  chs_bucket_unit #(
    .BW(BW)
  ) u_bucket (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .key     (cmd.key),
    .divisor (divisor),
    .done    (unit_done),
    .bucket  (bucket)
  );

  assign pool_full = (32'(count) >= ENTRIES);
  assign do_insert = (state == ST_FINISH) && (op == OP_INSERT) && !found && !pool_full;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = '0;
    if (state == ST_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_idx;
    end else if (do_insert) begin
      head_we          = 1'b1;
      head_wdata.valid = 1'b1;
      head_wdata.idx   = count[EW-1:0];
    end
  end

  assign ent_we = do_insert;

  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    head_rdata <= heads[bucket_q];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      keys[count[EW-1:0]]  <= key;
      links[count[EW-1:0]] <= head_q;
    end
    key_rdata  <= keys[slot];
    link_rdata <= links[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BW'(BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (unit_done) begin
            state <= ST_HEAD_RD;
          end
        end
        ST_HEAD_RD: state <= ST_HEAD_CHK;
        ST_HEAD_CHK: begin
          state <= head_rdata.valid ? ST_ENT_RD : ST_FINISH;
        end
        ST_ENT_RD: state <= ST_ENT_CHK;
        ST_ENT_CHK: begin
          if (key_rdata == key || !link_rdata.valid) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_ENT_RD;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (do_insert) begin
            count <= CW'(count + 1'b1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign count_ext = 32'(count);

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op    <= cmd.opcode;
          key   <= cmd.key;
          found <= 1'b0;
        end
      end
      ST_HASH: begin
        if (unit_done) begin
          bucket_q <= bucket;
        end
      end
      ST_HEAD_CHK: begin
        head_q <= head_rdata;
        slot   <= head_rdata.idx;
      end
      ST_ENT_CHK: begin
        if (key_rdata == key) begin
          found <= 1'b1;
        end else begin
          slot <= link_rdata.idx;
        end
      end
      ST_FINISH: begin
        result.found  <= found;
        result.status <= (op == OP_INSERT && !found && pool_full) ? STATUS_FULL : STATUS_OK;
        // count after this word
        result.entry_count <= do_insert ? COUNT_W'(count_ext + 32'd1) : count_ext[COUNT_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/chs_bucket_unit.sv @@
// Shared hash and remainder unit: djb2 over the key bytes, then hash mod bucket count.
module chs_bucket_unit #(
  parameter int BW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [chs_pkg::KEY_W-1:0] key,
  input  logic [chs_pkg::CFG_W-1:0] divisor,
  output logic                     done,
  output logic [BW-1:0]            bucket
);
  import chs_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HASH = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  localparam logic [3:0] HASH_LAST = 4'(HASH_STEPS - 1);
  localparam logic [3:0] DIV_LAST  = 4'(DIV_STEPS - 1);

  logic [1:0]       phase;
  logic [3:0]       step;
  logic [KEY_W-1:0] h;
  logic [KEY_W-1:0] kbuf;
  logic [CFG_W-1:0] dvs;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] rem_next;
  logic [KEY_W-1:0] h_step;
  logic [31:0]      rem_ext;

  assign h_step = (h << DJB_SHIFT) + h + {56'd0, kbuf[7:0]};

  // DIV_BITS restoring steps per cycle, remainder stays below the divisor
  always_comb begin
    logic [CFG_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[CFG_W-1:0], h[KEY_W-1-i]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
      end
    end
    rem_next = r[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_HASH;
            step  <= '0;
          end
        end
        PH_HASH: begin
          step <= step + 4'd1;
          if (step == HASH_LAST) begin
            phase <= PH_DIV;
            step  <= '0;
          end
        end
        PH_DIV: begin
          step <= step + 4'd1;
          if (step == DIV_LAST) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      h    <= DJB_SEED;
      kbuf <= key;
      dvs  <= divisor;
      rem  <= '0;
    end else if (phase == PH_HASH) begin
      h    <= h_step;
      kbuf <= kbuf >> 8;
    end else if (phase == PH_DIV) begin
      h   <= h << DIV_BITS;
      rem <= rem_next;
    end
  end

  assign rem_ext = 32'(rem);
  assign bucket  = rem_ext[BW-1:0];

endmodule
